### rtl/core/gain_frame_receiver_macros.svh
// Assertion macros shared by the gain frame receiver RTL.
`ifndef GAIN_FRAME_RECEIVER_MACROS_SVH
`define GAIN_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define GFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define GFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/gfr_pkg.sv
// Constants of the gain frame receiver.
package gfr_pkg;

  localparam int unsigned FRAME_LEN = 23;
  localparam int unsigned ADDR_W    = $clog2(FRAME_LEN);

  localparam logic [ADDR_W-1:0] SUM_POS   = ADDR_W'(22);
  localparam logic [ADDR_W-1:0] HEAD_POS  = ADDR_W'(1);
  localparam logic [ADDR_W-1:0] CODE_POS  = ADDR_W'(2);
  localparam logic [ADDR_W-1:0] WORD_BASE = ADDR_W'(4);

  localparam logic [7:0] SYNC_BYTE = 8'hAA;
  localparam logic [7:0] HEAD_BYTE = 8'hAF;
  localparam logic [7:0] CODE_ATT  = 8'h10;
  localparam logic [7:0] CODE_HGT  = 8'h11;
  localparam logic [7:0] ACK_ID    = 8'hEF;
  localparam logic [7:0] ACK_LEN   = 8'h02;

  // Sum of the four fixed leading bytes of the acknowledge frame, mod 256.
  localparam logic [7:0] ACK_SEED  = 8'(SYNC_BYTE + SYNC_BYTE + ACK_ID + ACK_LEN);

  // Index of the last gain word for each group.
  localparam logic [3:0] LAST_WORD_ATT = 4'd8;
  localparam logic [3:0] LAST_WORD_HGT = 4'd7;

  localparam logic [2:0] ACK_LAST = 3'd6;

endpackage

### rtl/core/gfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 23
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/gain_frame_receiver.sv
// Gain frame receiver: 23-byte frame collector, checker and gain/ack emitter.
// Bytes are taken one per cycle while a frame is being collected.
// A good frame end stalls the input while its results are emitted: each gain word
// passes S_HI, S_LO and S_OUT (two frame memory reads, then load), then each ack
// byte is emitted from S_ACK, for code 0x10 or 0x11; output stalls stretch this.
// Reset clears the control state to hunting; the frame memory is not cleared.
`include "gain_frame_receiver_macros.svh"

module gain_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic        out_gain_group,
  output logic [3:0]  out_word_index,
  output logic [15:0] out_word_value,
  output logic [7:0]  out_ack_byte,
  output logic        out_last
);

  typedef enum logic [2:0] {S_RX, S_HI, S_LO, S_OUT, S_ACK} state_t;

  state_t                          state_r, state_nxt;
  logic [gfr_pkg::ADDR_W-1:0]      pos_r, pos_nxt;
  logic [7:0]                      sum_r, sum_nxt;
  logic                            head_ok_r, head_ok_nxt;
  logic [7:0]                      code_r, code_nxt;
  logic [3:0]                      word_r, word_nxt;
  logic [2:0]                      ack_r, ack_nxt;
  logic [7:0]                      hi_r, hi_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic                            kind_r, kind_nxt;
  logic                            group_r, group_nxt;
  logic [3:0]                      index_r, index_nxt;
  logic [15:0]                     value_r, value_nxt;
  logic [7:0]                      ackb_r, ackb_nxt;
  logic                            last_r, last_nxt;

  logic                            in_acc;
  logic                            out_free;
  logic                            code_ok;
  logic                            group;
  logic [3:0]                      last_word;
  logic [7:0]                      ack_chk;
  logic [7:0]                      ack_sel;
  logic [gfr_pkg::ADDR_W-1:0]      raddr;
  logic [7:0]                      rdata;

  assign in_stall = (state_r != S_RX);
  assign in_acc   = in_valid && (state_r == S_RX);
  assign out_free = !out_valid_r || !out_stall;

  assign code_ok   = (code_r == gfr_pkg::CODE_ATT) || (code_r == gfr_pkg::CODE_HGT);
  assign group     = (code_r == gfr_pkg::CODE_HGT);
  assign last_word = group ? gfr_pkg::LAST_WORD_HGT : gfr_pkg::LAST_WORD_ATT;
  assign ack_chk   = gfr_pkg::ACK_SEED + code_r + sum_r;

  // High byte of word w sits at 4+2w, low byte right after it.
  assign raddr = gfr_pkg::WORD_BASE + {word_r, 1'b0}
               + gfr_pkg::ADDR_W'(state_r != S_HI);

  gfr_ram #(
    .WIDTH (8),
    .DEPTH (gfr_pkg::FRAME_LEN)
  ) u_frame_ram (
    .clk   (clk),
    .we    (in_acc),
    .waddr (pos_r),
    .wdata (in_rx_byte),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    case (ack_r)
      3'd0, 3'd1: ack_sel = gfr_pkg::SYNC_BYTE;
      3'd2:       ack_sel = gfr_pkg::ACK_ID;
      3'd3:       ack_sel = gfr_pkg::ACK_LEN;
      3'd4:       ack_sel = code_r;
      3'd5:       ack_sel = sum_r;
      default:    ack_sel = ack_chk;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    sum_nxt       = sum_r;
    head_ok_nxt   = head_ok_r;
    code_nxt      = code_r;
    word_nxt      = word_r;
    ack_nxt       = ack_r;
    hi_nxt        = hi_r;
    out_valid_nxt = out_valid_r && out_stall;
    kind_nxt      = kind_r;
    group_nxt     = group_r;
    index_nxt     = index_r;
    value_nxt     = value_r;
    ackb_nxt      = ackb_r;
    last_nxt      = last_r;

    case (state_r)
      S_RX: begin
        if (in_acc) begin
          if (pos_r == '0) begin
            if (in_rx_byte == gfr_pkg::SYNC_BYTE) begin
              sum_nxt = in_rx_byte;
              pos_nxt = gfr_pkg::ADDR_W'(1);
            end else begin
              sum_nxt = '0;
            end
          end else if (pos_r == gfr_pkg::SUM_POS) begin
            // Frame end: the checksum byte itself is compared, not stored in the sum.
            pos_nxt  = '0;
            word_nxt = '0;
            ack_nxt  = '0;
            if ((sum_r == in_rx_byte) && head_ok_r && code_ok) begin
              state_nxt = S_HI;
            end
          end else begin
            sum_nxt = sum_r + in_rx_byte;
            pos_nxt = pos_r + gfr_pkg::ADDR_W'(1);
            if (pos_r == gfr_pkg::HEAD_POS) begin
              head_ok_nxt = (in_rx_byte == gfr_pkg::HEAD_BYTE);
            end
            if (pos_r == gfr_pkg::CODE_POS) begin
              code_nxt = in_rx_byte;
            end
          end
        end
      end
      S_HI: begin
        state_nxt = S_LO;
      end
      S_LO: begin
        hi_nxt    = rdata;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // The read address holds here, so the low byte stays put while stalled.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = 1'b0;
          group_nxt     = group;
          index_nxt     = word_r;
          value_nxt     = {hi_r, rdata};
          ackb_nxt      = '0;
          last_nxt      = 1'b0;
          word_nxt      = word_r + 4'd1;
          state_nxt     = (word_r == last_word) ? S_ACK : S_HI;
        end
      end
      S_ACK: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = 1'b1;
          group_nxt     = group;
          index_nxt     = '0;
          value_nxt     = '0;
          ackb_nxt      = ack_sel;
          last_nxt      = (ack_r == gfr_pkg::ACK_LAST);
          ack_nxt       = ack_r + 3'd1;
          if (ack_r == gfr_pkg::ACK_LAST) begin
            state_nxt = S_RX;
          end
        end
      end
      default: begin
        state_nxt = S_RX;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RX;
      pos_r       <= '0;
      sum_r       <= '0;
      head_ok_r   <= 1'b0;
      word_r      <= '0;
      ack_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      sum_r       <= sum_nxt;
      head_ok_r   <= head_ok_nxt;
      word_r      <= word_nxt;
      ack_r       <= ack_nxt;
      out_valid_r <= out_valid_nxt;
    end
    code_r  <= code_nxt;
    hi_r    <= hi_nxt;
    kind_r  <= kind_nxt;
    group_r <= group_nxt;
    index_r <= index_nxt;
    value_r <= value_nxt;
    ackb_r  <= ackb_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = kind_r;
  assign out_gain_group = group_r;
  assign out_word_index = index_r;
  assign out_word_value = value_r;
  assign out_ack_byte   = ackb_r;
  assign out_last       = last_r;

  `GFR_ASSERT_NOW(a_last_on_ack, out_valid_r && last_r, kind_r, "last flag on a gain word")
  `GFR_ASSERT_NOW(a_word_range, out_valid_r && !kind_r, index_r <= gfr_pkg::LAST_WORD_ATT,
                  "gain word index out of range")
  `GFR_ASSERT_NEXT(a_frame_end, in_acc && (pos_r == gfr_pkg::SUM_POS), pos_r == '0,
                   "byte position not back to hunting after frame end")
  `GFR_ASSERT_NOW(a_ack_clean, out_valid_r && kind_r, (value_r == '0) && (index_r == '0),
                  "ack item carries word fields")

endmodule
